// ===== design/assert_macros.svh =====
// Assertion macros used by the packer's merge stage.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define HBP_ASSERT_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent checked at the edge after the antecedent
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hbp_pkg.sv =====
// Shared types, constants and the table-load function of the bit packer.
// No dependencies.
package hbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 9;
   localparam int BYTE_W       = 8;
   localparam int CNT_W        = 3;
   localparam int TABLE_DEPTH  = 257;
   localparam int MERGE_W      = CODE_W + BYTE_W;
   localparam int EMIT_CNT_W   = 3;

   localparam logic [SYM_W-1:0] END_INDEX = SYM_W'(TABLE_DEPTH - 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT =
      LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_END    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } entry_type;

   typedef struct packed {
      logic [MERGE_W-1:0]    word;
      logic [EMIT_CNT_W-1:0] count;
   } emit_type;

   function automatic entry_type load_entry(input logic [LEN_W-1:0] len,
                                            input logic [CODE_W-1:0] bits);
      entry_type         e;
      logic [LEN_W-1:0]  l;
      logic [CODE_W-1:0] mask;
      l = (len > LEN_LIMIT) ? LEN_LIMIT : len;
      if (l >= LEN_W'(CODE_W)) begin
         mask = '1;
      end else begin
         mask = (CODE_W'(1) << l) - CODE_W'(1);
      end
      e.len  = l;
      e.bits = bits & mask;
      return e;
   endfunction

endpackage

// ===== design/hbp_code_table.sv =====
// Code table memory: one write port, one read port with registered data.
// Depends on hbp_pkg.
module hbp_code_table (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [hbp_pkg::SYM_W-1:0]   wr_addr,
   input  hbp_pkg::entry_type          wr_data,
   input  logic                        rd_en,
   input  logic [hbp_pkg::SYM_W-1:0]   rd_addr,
   output hbp_pkg::entry_type          rd_data
);

   hbp_pkg::entry_type mem [hbp_pkg::TABLE_DEPTH];
   hbp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hbp_merge.sv =====
// Merge stage: joins the read code with the bit accumulator and hands
// complete bytes to the emitter. Depends on hbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hbp_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_end,
   input  hbp_pkg::entry_type rd_entry,
   input  logic               emit_free,
   output logic               take,
   output logic               emit_load,
   output hbp_pkg::emit_type  emit
);

   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_end_ff, s1_end_in;
   logic [hbp_pkg::BYTE_W-1:0]        acc_ff, acc_in;
   logic [hbp_pkg::CNT_W-1:0]         acc_cnt_ff, acc_cnt_in;
   logic [hbp_pkg::MERGE_W-1:0]       merged;
   logic [hbp_pkg::LEN_W-1:0]         total;
   logic [hbp_pkg::EMIT_CNT_W-1:0]    full;
   logic [hbp_pkg::CNT_W-1:0]         rem;
   logic [hbp_pkg::EMIT_CNT_W-1:0]    count;
   logic [hbp_pkg::BYTE_W-1:0]        tail;
   logic                              s1_advance;

   always_comb begin
      merged = (hbp_pkg::MERGE_W'(rd_entry.bits) << acc_cnt_ff)
             | hbp_pkg::MERGE_W'(acc_ff);
      total  = rd_entry.len + hbp_pkg::LEN_W'(acc_cnt_ff);
      full   = total[hbp_pkg::LEN_W-1:hbp_pkg::CNT_W];
      rem    = total[hbp_pkg::CNT_W-1:0];
      case (full)
         3'd0:    tail = merged[7:0];
         3'd1:    tail = merged[15:8];
         3'd2:    tail = merged[23:16];
         3'd3:    tail = merged[31:24];
         3'd4:    tail = merged[39:32];
         default: tail = '0;
      endcase
      if (s1_end_ff) begin
         count = full + hbp_pkg::EMIT_CNT_W'(rem != '0);
      end else begin
         count = full;
      end
   end

   assign s1_advance = s1_valid_ff && ((count == '0) || emit_free);
   assign take       = !s1_valid_ff || s1_advance;
   assign emit_load  = s1_valid_ff && (count != '0) && emit_free;
   assign emit.word  = merged;
   assign emit.count = count;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_end_in   = s1_end_ff;
      acc_in      = acc_ff;
      acc_cnt_in  = acc_cnt_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
         if (s1_end_ff) begin
            acc_in     = '0;
            acc_cnt_in = '0;
         end else begin
            acc_in     = tail;
            acc_cnt_in = rem;
         end
      end
      if (take && in_valid) begin
         s1_valid_in = 1'b1;
         s1_end_in   = in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_end_ff   <= 1'b0;
         acc_ff      <= '0;
         acc_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_end_ff   <= s1_end_in;
         acc_ff      <= acc_in;
         acc_cnt_ff  <= acc_cnt_in;
      end
   end

   `HBP_ASSERT_NOW(a_load_when_free, emit_load |-> emit_free, "emitter loaded while busy")
   `HBP_ASSERT_NEXT(a_end_clears, s1_advance && s1_end_ff, acc_cnt_ff == '0, "end left bits")
   `HBP_ASSERT_NEXT(a_stall_holds, s1_valid_ff && !s1_advance, s1_valid_ff, "stalled item lost")

endmodule

// ===== design/hbp_emit.sv =====
// Byte emitter: holds up to five packed bytes and sends one per beat.
// Depends on hbp_pkg.
module hbp_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       emit_load,
   input  hbp_pkg::emit_type          emit,
   output logic                       emit_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [hbp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last
);

   logic [hbp_pkg::MERGE_W-1:0]    word_ff, word_in;
   logic [hbp_pkg::EMIT_CNT_W-1:0] left_ff, left_in;
   logic                           beat;

   assign rsp_valid    = (left_ff != '0);
   assign rsp_last     = (left_ff == hbp_pkg::EMIT_CNT_W'(1));
   assign rsp_out_byte = word_ff[hbp_pkg::BYTE_W-1:0];
   assign beat         = rsp_valid && rsp_ready;
   assign emit_free    = (left_ff == '0) || (rsp_last && rsp_ready);

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      if (emit_load) begin
         word_in = emit.word;
         left_in = emit.count;
      end else if (beat) begin
         word_in = word_ff >> hbp_pkg::BYTE_W;
         left_in = left_ff - hbp_pkg::EMIT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== design/huffman_bit_packer_core.sv =====
// Huffman bit packer: table load, LSB-first code packing, byte output.
// Request beats carry a kind (load, encode, end), a symbol and, for
// loads, a code length and code bits. Loads write the code table and
// give no result. Encode beats append the symbol's code to the bit
// accumulator; end beats append the end code and flush a partial byte
// with zero padding. Each complete byte leaves as one rsp beat, and
// rsp_last marks the final byte of the request that caused it.
// Path: the table read is registered at the request beat; the merge into
// the byte emitter is combinational, and the emitter registers the bytes.
// Throughput: one request per cycle when it gives no byte and the merge
// stage holds no stalled request; otherwise one rsp beat per output byte
// (one to five), set by the byte-wide rsp port. The merge of the next
// request overlaps the last byte's beat.
// Reset clears the accumulator and pipeline; table entries are
// undefined until loaded and need no clearing pass.
// When the receiver stalls, the emitter holds its byte; the merge stage
// holds a next request that gives bytes, and req_ready then drops.
// Depends on hbp_pkg, hbp_code_table, hbp_merge, hbp_emit.
module huffman_bit_packer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [hbp_pkg::SYM_W-1:0]         req_symbol,
   input  logic [hbp_pkg::LEN_W-1:0]         req_code_length,
   input  logic [hbp_pkg::CODE_W-1:0]        req_code_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hbp_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last
);

   hbp_pkg::kind_type           kind;
   logic                        accept;
   logic                        in_range;
   logic                        wr_en;
   logic                        rd_en;
   logic [hbp_pkg::SYM_W-1:0]   rd_addr;
   hbp_pkg::entry_type          rd_entry;
   logic                        take;
   logic                        emit_load;
   logic                        emit_free;
   hbp_pkg::emit_type           emit;

   assign kind      = hbp_pkg::kind_type'(req_kind);
   assign req_ready = take;
   assign accept    = req_valid && req_ready;
   assign in_range  = (req_symbol <= hbp_pkg::END_INDEX);
   assign wr_en     = accept && (kind == hbp_pkg::KIND_LOAD) && in_range;
   assign rd_en     = accept && (((kind == hbp_pkg::KIND_ENCODE) && in_range)
                                 || (kind == hbp_pkg::KIND_END));
   assign rd_addr   = (kind == hbp_pkg::KIND_END) ? hbp_pkg::END_INDEX : req_symbol;

   hbp_code_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_symbol),
      .wr_data (hbp_pkg::load_entry(req_code_length, req_code_bits)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   hbp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_en),
      .in_end    (kind == hbp_pkg::KIND_END),
      .rd_entry  (rd_entry),
      .emit_free (emit_free),
      .take      (take),
      .emit_load (emit_load),
      .emit      (emit)
   );

   hbp_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .emit_load    (emit_load),
      .emit         (emit),
      .emit_free    (emit_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== dv/huffman_bit_packer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for huffman_bit_packer_core: table loads, code packing, end flushes.
// Predicts every output byte and its last flag, and compares them in order.
// Depends on hbp_pkg and the huffman_bit_packer_core RTL.

class byte_stream_predictor;
   typedef struct {
      logic [hbp_pkg::BYTE_W-1:0] value;
      logic                       last;
   } byte_beat_type;

   hbp_pkg::entry_type         code_table [hbp_pkg::TABLE_DEPTH];
   logic [hbp_pkg::BYTE_W-1:0] acc;
   int unsigned                nbits;
   logic [hbp_pkg::BYTE_W-1:0] fresh_bytes [$];
   byte_beat_type              expected_bytes [$];
   int unsigned                mismatches;

   function new();
      foreach (code_table[i]) code_table[i] = '0;
      acc        = '0;
      nbits      = 0;
      mismatches = 0;
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction

   function void append_code(int unsigned idx);
      hbp_pkg::entry_type e;
      int unsigned        k;
      e = code_table[idx];
      for (k = 0; k < e.len; k++) begin
         acc[nbits] = e.bits[k];
         nbits++;
         if (nbits == hbp_pkg::BYTE_W) begin
            fresh_bytes.push_back(acc);
            acc   = '0;
            nbits = 0;
         end
      end
   endfunction

   function void absorb_request(input logic [1:0] kind,
                                input logic [hbp_pkg::SYM_W-1:0] sym,
                                input logic [hbp_pkg::LEN_W-1:0] len,
                                input logic [hbp_pkg::CODE_W-1:0] bits);
      logic [hbp_pkg::LEN_W-1:0]  l;
      logic [hbp_pkg::CODE_W:0]   mask;
      byte_beat_type              beat;
      fresh_bytes.delete();
      case (kind)
         hbp_pkg::KIND_LOAD: begin
            if (sym <= hbp_pkg::END_INDEX) begin
               l    = (len > hbp_pkg::LEN_LIMIT) ? hbp_pkg::LEN_LIMIT : len;
               mask = ((hbp_pkg::CODE_W+1)'(1) << l) - (hbp_pkg::CODE_W+1)'(1);
               code_table[sym].len  = l;
               code_table[sym].bits = bits & mask[hbp_pkg::CODE_W-1:0];
            end
         end
         hbp_pkg::KIND_ENCODE: begin
            if (sym <= hbp_pkg::END_INDEX) append_code(sym);
         end
         hbp_pkg::KIND_END: begin
            append_code(hbp_pkg::END_INDEX);
            if (nbits != 0) fresh_bytes.push_back(acc);
            acc   = '0;
            nbits = 0;
         end
         default: ;
      endcase
      foreach (fresh_bytes[i]) begin
         beat.value = fresh_bytes[i];
         beat.last  = (i == fresh_bytes.size() - 1);
         expected_bytes.push_back(beat);
      end
   endfunction

   function void match_byte(input logic [hbp_pkg::BYTE_W-1:0] value, input logic last);
      byte_beat_type want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: unexpected byte beat, expected none, actual out_byte %02h last %0b",
                  $time, value, last);
         mismatches++;
      end else begin
         want = expected_bytes.pop_front();
         if (value !== want.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            mismatches++;
         end
      end
   endfunction
endclass

module huffman_bit_packer_core_test;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   hbp_pkg::kind_type             req_kind;
   logic [hbp_pkg::SYM_W-1:0]     req_symbol;
   logic [hbp_pkg::LEN_W-1:0]     req_code_length;
   logic [hbp_pkg::CODE_W-1:0]    req_code_bits;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [hbp_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_last;

   byte_stream_predictor packer;
   bit                   hold_req;
   bit                   loaded_map [hbp_pkg::TABLE_DEPTH];
   int                   loaded_syms [$];
   int                   counted;
   int                   burst_left;

   huffman_bit_packer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) packer.match_byte(rsp_out_byte, rsp_last);
         if (req_valid && req_ready)
            packer.absorb_request(req_kind, req_symbol, req_code_length, req_code_bits);
      end
   end

   initial begin
      int mode;
      int span;
      int period;
      int phase;
      rsp_ready = 1'b0;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(8, 60);
         period = $urandom_range(2, 5);
         for (phase = 0; phase < span; phase++) begin
            @(negedge clock);
            if (hold_req) begin
               rsp_ready <= 1'b0;
               repeat (80) @(negedge clock);
               hold_req = 1'b0;
            end else begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= (phase % period == 0);
                  default: rsp_ready <= ($urandom_range(0, 6) != 0);
               endcase
            end
         end
      end
   end

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer(input hbp_pkg::kind_type kind, input int sym, input int len,
                        input logic [hbp_pkg::CODE_W-1:0] bits);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap > 0) pause_sender(gap);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_kind        <= kind;
      req_symbol      <= hbp_pkg::SYM_W'(sym);
      req_code_length <= hbp_pkg::LEN_W'(len);
      req_code_bits   <= bits;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (kind == hbp_pkg::KIND_LOAD && sym <= hbp_pkg::TABLE_DEPTH - 1 &&
          !loaded_map[sym]) begin
         loaded_map[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
      if (kind == hbp_pkg::KIND_END ||
          ((kind == hbp_pkg::KIND_LOAD || kind == hbp_pkg::KIND_ENCODE) &&
           sym <= hbp_pkg::TABLE_DEPTH - 1))
         counted++;
   endtask

   task automatic wait_drained();
      pause_sender(1);
      while (packer.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic offer_random_load();
      int sym;
      int len;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) sym = hbp_pkg::TABLE_DEPTH - 1;
      else if (r == 1) sym = $urandom_range(hbp_pkg::TABLE_DEPTH, 511);
      else sym = $urandom_range(0, 255);
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(0, 10);
      else if (r < 9) len = $urandom_range(11, 32);
      else len = $urandom_range(33, 63);
      offer(hbp_pkg::KIND_LOAD, sym, len, $urandom);
   endtask

   task automatic offer_noise();
      if ($urandom_range(0, 1) == 0)
         offer(hbp_pkg::KIND_NONE, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      else
         offer(hbp_pkg::KIND_ENCODE, $urandom_range(hbp_pkg::TABLE_DEPTH, 511),
               $urandom_range(0, 63), $urandom);
   endtask

   task automatic run_stream();
      int n_loads;
      int n_codes;
      int i;
      int sym;
      n_loads = $urandom_range(0, 3);
      for (i = 0; i < n_loads; i++) offer_random_load();
      n_codes = $urandom_range(1, 12);
      for (i = 0; i < n_codes; i++) begin
         if ($urandom_range(0, 11) == 0) offer_noise();
         if ($urandom_range(0, 9) == 0) sym = hbp_pkg::TABLE_DEPTH - 1;
         else sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
         offer(hbp_pkg::KIND_ENCODE, sym, $urandom_range(0, 63), $urandom);
      end
      if ($urandom_range(0, 9) != 0)
         offer(hbp_pkg::KIND_END, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
   endtask

   initial begin
      int streams;
      int guard;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = hbp_pkg::KIND_NONE;
      req_symbol      = '0;
      req_code_length = '0;
      req_code_bits   = '0;
      hold_req        = 1'b0;
      counted         = 0;
      burst_left      = 0;
      packer          = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer(hbp_pkg::KIND_LOAD, hbp_pkg::TABLE_DEPTH - 1, 32, $urandom);
      offer(hbp_pkg::KIND_LOAD, 0, 1, 32'hFFFF_FFFF);
      offer(hbp_pkg::KIND_LOAD, 255, 32, 32'hFFFF_FFFF);
      offer(hbp_pkg::KIND_LOAD, 1, 63, $urandom);
      offer(hbp_pkg::KIND_LOAD, 2, 0, $urandom);
      offer(hbp_pkg::KIND_LOAD, 3, 7, 32'h0);
      offer(hbp_pkg::KIND_LOAD, 511, 5, $urandom);
      offer(hbp_pkg::KIND_LOAD, hbp_pkg::TABLE_DEPTH, 9, $urandom);
      offer(hbp_pkg::KIND_ENCODE, 3, 0, 32'h0);
      offer(hbp_pkg::KIND_END, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_ENCODE, 0, 0, 32'h0);
      offer(hbp_pkg::KIND_ENCODE, 255, 63, 32'hFFFF_FFFF);
      offer(hbp_pkg::KIND_ENCODE, 1, 0, 32'h0);
      offer(hbp_pkg::KIND_ENCODE, 2, 0, 32'h0);
      offer(hbp_pkg::KIND_ENCODE, hbp_pkg::TABLE_DEPTH - 1, 0, 32'h0);
      offer(hbp_pkg::KIND_ENCODE, 300, $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_ENCODE, 511, 63, 32'hFFFF_FFFF);
      offer(hbp_pkg::KIND_NONE, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_END, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_LOAD, hbp_pkg::TABLE_DEPTH - 1, 0, 32'hFFFF_FFFF);
      offer(hbp_pkg::KIND_END, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_LOAD, hbp_pkg::TABLE_DEPTH - 1, 8, $urandom);
      offer(hbp_pkg::KIND_END, $urandom_range(0, 511), $urandom_range(0, 63), $urandom);
      offer(hbp_pkg::KIND_ENCODE, 0, 0, 32'h0);
      offer(hbp_pkg::KIND_END, 0, 0, 32'h0);
      wait_drained();

      streams = 0;
      while (counted < 160) begin
         if (streams == 4) hold_req = 1'b1;
         if (streams == 12) wait_drained();
         run_stream();
         streams++;
      end

      pause_sender(1);
      guard = 0;
      while (packer.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (packer.pending() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, packer.pending());
         packer.mismatches++;
      end
      if (packer.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
